>>> hdl/kts_pkg.sv
// Shared types, command and status codes, constants and a saturation helper for the keyframe track sampler.
package kts_pkg;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic        [5:0]  track;
    logic        [4:0]  key_index;
    logic        [5:0]  key_count;
    logic               spherical;
    logic        [30:0] key_time;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic signed [31:0] comp_w;
    logic        [30:0] sample_time;
    logic               looping;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic        [30:0] local_time;
    logic        [1:0]  status;
  } res_t;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  localparam logic [30:0] DUR_RESET = 31'd65536;
  localparam logic [16:0] FRAC_ONE  = 17'h10000;
  localparam logic [1:0]  LAST_COMP = 2'd3;
  localparam logic [3:0]  TOP_BIT   = 4'd15;

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/keyframe_track_sampler_top.sv
// Keyframe track sampler: key and track stores, sequencer, shared divider, root and multiplier.
// Write and set transactions go from idle straight to the done state, which raises done_o.
// A sample wraps or clamps the time, walks the keys, divides out the fraction, then
// interpolates linearly or by slerp bisection, one step per fraction bit (16 bits), using
// the bit-serial 64-step divider run four times per bisection step.
// One transaction at a time; the result strobe cannot be stalled.
// Reset clears the sequencer and the track valid flags, and sets the clip duration to 1.0.
module keyframe_track_sampler_top #(
  parameter int MAX_KEYS   = 32,
  parameter int MAX_TRACKS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  kts_pkg::item_t item_i,
  output logic           busy_o,
  output logic           done_o,
  output kts_pkg::res_t  result_o,
  input  logic           cfg_we_i,
  input  logic [30:0]    cfg_wdata_i
);

  localparam int SW  = $clog2(MAX_KEYS + 1);
  localparam int KAW = $clog2(MAX_TRACKS * MAX_KEYS);
  localparam int TAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  typedef enum logic [21:0] {
    S_IDLE = 22'h000001,
    S_TRK  = 22'h000002,
    S_MOD  = 22'h000004,
    S_CHK  = 22'h000008,
    S_SRD  = 22'h000010,
    S_SCMP = 22'h000020,
    S_SEG  = 22'h000040,
    S_HOLD = 22'h000080,
    S_VALA = 22'h000100,
    S_VALB = 22'h000200,
    S_FRAC = 22'h000400,
    S_KIND = 22'h000800,
    S_DMUL = 22'h001000,
    S_DACC = 22'h002000,
    S_DCHK = 22'h004000,
    S_SQRT = 22'h008000,
    S_SDIV = 22'h010000,
    S_SUPD = 22'h020000,
    S_SOUT = 22'h040000,
    S_LMUL = 22'h080000,
    S_LACC = 22'h100000,
    S_DONE = 22'h200000
  } state_e;

  state_e state_q, state_d;

  logic [30:0]           dur_q;
  logic [MAX_TRACKS-1:0] trk_vld_q;

  kts_pkg::item_t     item_q;
  logic [SW-1:0]      len_q, s_q;
  logic               sph_q;
  logic [30:0]        t_q, start_q, end_q;
  logic [16:0]        f_q;
  logic [1:0]         comp_q;
  logic [3:0]         k_q;
  logic signed [51:0] dot_q;
  logic signed [67:0] prod_q;
  logic signed [31:0] pa_q  [4];
  logic signed [32:0] pb_q  [4];
  logic signed [47:0] a_q   [4];
  logic signed [47:0] b_q   [4];
  logic signed [47:0] m_q   [4];
  logic signed [31:0] out_q [4];
  logic [1:0]         status_q;
  logic [30:0]        ltime_q;

  // shared divider
  logic [63:0] dv_quo_q;
  logic [31:0] dv_rem_q, dv_den_q;
  logic [6:0]  dv_cnt_q;
  logic        dv_neg_q;
  logic [32:0] dv_rem_sh;
  logic        dv_ge;

  // integer square root
  logic [61:0] sq_rad_q;
  logic [34:0] sq_rem_q;
  logic [30:0] sq_root_q;
  logic [4:0]  sq_cnt_q;
  logic [34:0] sq_rem_new, sq_trial;
  logic        sq_ge;

  function automatic logic [KAW-1:0] key_addr(input logic [5:0] trk, input logic [SW-1:0] k);
    return KAW'(32'(trk) * 32'(MAX_KEYS) + 32'(k));
  endfunction

  // ---------------------------------------------------------------- stores
  logic            accept;
  logic            trk_in_ok, key_in_ok;
  logic            key_we, trk_we;
  logic [KAW-1:0]  key_waddr, ts_raddr, vl_raddr;
  logic [TAW-1:0]  trk_waddr;
  logic [SW-1:0]   len_sat;
  logic [30:0]     ts_rdata;
  logic [127:0]    vl_rdata;
  logic [SW:0]     tr_rdata;
  logic signed [31:0] vl_comp [4];

  assign busy_o    = (state_q != S_IDLE);
  assign accept    = start_i && !busy_o;
  assign trk_in_ok = 32'(item_i.track) < 32'(MAX_TRACKS);
  assign key_in_ok = 32'(item_i.key_index) < 32'(MAX_KEYS);
  assign key_we    = accept && (item_i.cmd == kts_pkg::CMD_WRITE) && trk_in_ok && key_in_ok;
  assign trk_we    = accept && (item_i.cmd == kts_pkg::CMD_SET) && trk_in_ok;
  assign key_waddr = key_addr(item_i.track, SW'(item_i.key_index));
  assign trk_waddr = TAW'(32'(item_i.track));
  assign len_sat   = (32'(item_i.key_count) > 32'(MAX_KEYS)) ? SW'(MAX_KEYS)
                                                             : SW'(item_i.key_count);

  assign ts_raddr = key_addr(item_q.track, s_q);

  always_comb begin
    vl_raddr = key_addr(item_q.track, s_q - SW'(1));
    if (state_q == S_SEG && (len_q == SW'(1) || s_q == '0)) begin
      vl_raddr = key_addr(item_q.track, '0);
    end else if (state_q == S_VALA) begin
      vl_raddr = key_addr(item_q.track, (s_q >= len_q) ? '0 : s_q);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_comp
    assign vl_comp[g] = $signed(vl_rdata[32*g +: 32]);
  end

  kts_ram #(.WIDTH(31), .DEPTH(MAX_TRACKS * MAX_KEYS)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(item_i.key_time),
    .raddr_i(ts_raddr),
    .rdata_o(ts_rdata)
  );

  kts_ram #(.WIDTH(128), .DEPTH(MAX_TRACKS * MAX_KEYS)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i({item_i.comp_w, item_i.comp_z, item_i.comp_y, item_i.comp_x}),
    .raddr_i(vl_raddr),
    .rdata_o(vl_rdata)
  );

  kts_ram #(.WIDTH(SW + 1), .DEPTH(MAX_TRACKS)) u_track_ram (
    .clk_i  (clk_i),
    .we_i   (trk_we),
    .waddr_i(trk_waddr),
    .wdata_i({item_i.spherical, len_sat}),
    .raddr_i(trk_waddr),
    .rdata_o(tr_rdata)
  );

  // ---------------------------------------------------------------- arithmetic
  logic               trk_vld;
  logic signed [33:0] mul_a, mul_b;
  logic signed [51:0] dot_abs;
  logic               dot_neg;
  logic signed [32:0] pb_neg [4];
  logic [1:0]         sl_idx;
  logic signed [48:0] sl_sum;
  logic [63:0]        sl_num, sl_mag, dv_signed;
  logic [30:0]        c_src;
  logic [31:0]        c_sum;
  logic [15:0]        f_lo;

  assign trk_vld = (32'(item_q.track) < 32'(MAX_TRACKS)) &&
                   trk_vld_q[TAW'(32'(item_q.track))];

  assign dv_rem_sh = {dv_rem_q, dv_quo_q[63]};
  assign dv_ge     = dv_rem_sh >= {1'b0, dv_den_q};
  assign dv_signed = dv_neg_q ? (~dv_quo_q + 64'd1) : dv_quo_q;

  assign sq_rem_new = {sq_rem_q[32:0], sq_rad_q[61:60]};
  assign sq_trial   = {2'b00, sq_root_q, 2'b01};
  assign sq_ge      = sq_rem_new >= sq_trial;

  always_comb begin
    if (state_q == S_LMUL) begin
      mul_a = 34'(pb_q[comp_q]) - 34'(pa_q[comp_q]);
      mul_b = $signed({17'b0, f_q});
    end else begin
      mul_a = 34'(pa_q[comp_q]);
      mul_b = 34'(pb_q[comp_q]);
    end
  end

  assign dot_neg = dot_q[51];
  assign dot_abs = dot_neg ? -dot_q : dot_q;
  for (genvar g = 0; g < 4; g++) begin : g_neg
    assign pb_neg[g] = dot_neg ? -pb_q[g] : pb_q[g];
  end

  // Midpoint numerator (a + b) * 2^15, split into sign and magnitude.
  assign sl_idx = (state_q == S_SQRT) ? 2'd0 : comp_q + 2'd1;
  assign sl_sum = 49'(a_q[sl_idx]) + 49'(b_q[sl_idx]);
  assign sl_num = {sl_sum, 15'b0};
  assign sl_mag = sl_sum[48] ? (~sl_num + 64'd1) : sl_num;

  assign c_src = (state_q == S_DCHK) ? {1'b0, dot_abs[15:0], 14'b0} : sq_root_q;
  assign c_sum = (32'd1 << 30) + 32'(c_src);
  assign f_lo  = f_q[15:0];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) begin
        state_d = (item_i.cmd == kts_pkg::CMD_SAMPLE) ? S_TRK : S_DONE;
      end
      S_TRK:  state_d = (item_q.looping && dur_q != '0) ? S_MOD : S_CHK;
      S_MOD:  if (dv_cnt_q == '0) begin
        state_d = S_CHK;
      end
      S_CHK:  state_d = (len_q == '0) ? S_DONE : S_SRD;
      S_SRD:  state_d = (s_q < len_q) ? S_SCMP : S_SEG;
      S_SCMP: state_d = (t_q >= ts_rdata) ? S_SRD : S_SEG;
      S_SEG:  state_d = (len_q == SW'(1) || s_q == '0) ? S_HOLD : S_VALA;
      S_HOLD: state_d = S_DONE;
      S_VALA: state_d = S_VALB;
      S_VALB: state_d = (end_q > start_q) ? S_FRAC : S_KIND;
      S_FRAC: if (dv_cnt_q == '0) begin
        state_d = S_KIND;
      end
      S_KIND: state_d = sph_q ? S_DMUL : S_LMUL;
      S_DMUL: state_d = S_DACC;
      S_DACC: state_d = (comp_q == kts_pkg::LAST_COMP) ? S_DCHK : S_DMUL;
      S_DCHK: begin
        if (dot_abs > 52'sd65535) begin
          state_d = S_LMUL;
        end else if (f_q[16]) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: if (sq_cnt_q == '0) begin
        state_d = S_SDIV;
      end
      S_SDIV: if (dv_cnt_q == '0 && comp_q == kts_pkg::LAST_COMP) begin
        state_d = S_SUPD;
      end
      S_SUPD: state_d = (k_q == '0) ? S_SOUT : S_SQRT;
      S_SOUT: state_d = S_DONE;
      S_LMUL: state_d = S_LACC;
      S_LACC: state_d = (comp_q == kts_pkg::LAST_COMP) ? S_DONE : S_LMUL;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dur_q     <= kts_pkg::DUR_RESET;
      trk_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        dur_q <= cfg_wdata_i;
      end
      if (trk_we) begin
        trk_vld_q[trk_waddr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    // advance the running divider and root by one step
    if (dv_cnt_q != '0) begin
      dv_rem_q <= dv_ge ? 32'(dv_rem_sh - {1'b0, dv_den_q}) : dv_rem_sh[31:0];
      dv_quo_q <= {dv_quo_q[62:0], dv_ge};
      dv_cnt_q <= dv_cnt_q - 7'd1;
    end
    if (sq_cnt_q != '0) begin
      sq_rem_q  <= sq_ge ? (sq_rem_new - sq_trial) : sq_rem_new;
      sq_root_q <= {sq_root_q[29:0], sq_ge};
      sq_rad_q  <= {sq_rad_q[59:0], 2'b00};
      sq_cnt_q  <= sq_cnt_q - 5'd1;
    end

    case (state_q)
      S_IDLE: if (accept) begin
        item_q   <= item_i;
        status_q <= kts_pkg::ST_OK;
        ltime_q  <= '0;
        dv_cnt_q <= '0;
        sq_cnt_q <= '0;
        for (int i = 0; i < 4; i++) begin
          out_q[i] <= '0;
        end
      end
      S_TRK: begin
        len_q <= trk_vld ? tr_rdata[SW-1:0] : '0;
        sph_q <= trk_vld && tr_rdata[SW];
        if (item_q.looping) begin
          t_q      <= '0;
          dv_quo_q <= {item_q.sample_time, 33'b0};
          dv_rem_q <= '0;
          dv_den_q <= {1'b0, dur_q};
          dv_cnt_q <= 7'd31;
        end else begin
          t_q <= (item_q.sample_time > dur_q) ? dur_q : item_q.sample_time;
        end
      end
      S_MOD: if (dv_cnt_q == '0) begin
        t_q <= dv_rem_q[30:0];
      end
      S_CHK: begin
        ltime_q <= t_q;
        s_q     <= '0;
        if (len_q == '0) begin
          status_q <= kts_pkg::ST_EMPTY;
        end
      end
      S_SCMP: begin
        if (t_q >= ts_rdata) begin
          start_q <= ts_rdata;
          s_q     <= s_q + SW'(1);
        end else begin
          end_q <= ts_rdata;
        end
      end
      S_SEG: if (s_q >= len_q) begin
        // past the last key: segment closes at the clip end
        end_q <= dur_q;
      end
      S_HOLD: begin
        status_q <= (len_q == SW'(1)) ? kts_pkg::ST_SINGLE : kts_pkg::ST_OK;
        for (int i = 0; i < 4; i++) begin
          out_q[i] <= vl_comp[i];
        end
      end
      S_VALA: begin
        for (int i = 0; i < 4; i++) begin
          pa_q[i] <= vl_comp[i];
        end
      end
      S_VALB: begin
        comp_q <= '0;
        dot_q  <= '0;
        f_q    <= '0;
        for (int i = 0; i < 4; i++) begin
          pb_q[i] <= 33'(vl_comp[i]);
        end
        if (end_q > start_q) begin
          dv_quo_q <= {t_q - start_q, 33'b0};
          dv_rem_q <= '0;
          dv_den_q <= {1'b0, end_q - start_q};
          dv_cnt_q <= 7'd47;
        end
      end
      S_FRAC: if (dv_cnt_q == '0) begin
        f_q <= (dv_quo_q > 64'(kts_pkg::FRAC_ONE)) ? kts_pkg::FRAC_ONE : dv_quo_q[16:0];
      end
      S_DMUL, S_LMUL: prod_q <= mul_a * mul_b;
      S_DACC: begin
        dot_q  <= dot_q + 52'(prod_q >>> 16);
        comp_q <= comp_q + 2'd1;
      end
      S_DCHK: begin
        comp_q <= '0;
        for (int i = 0; i < 4; i++) begin
          pb_q[i] <= pb_neg[i];
          out_q[i] <= kts_pkg::sat32(64'(pb_neg[i]));
          a_q[i]   <= 48'(pa_q[i]) <<< 8;
          b_q[i]   <= 48'(pb_neg[i]) <<< 8;
        end
        k_q       <= kts_pkg::TOP_BIT;
        sq_rad_q  <= {1'b0, c_sum[31:1], 30'b0};
        sq_rem_q  <= '0;
        sq_root_q <= '0;
        sq_cnt_q  <= 5'd31;
      end
      S_SQRT, S_SDIV: begin
        if (state_q == S_SDIV && dv_cnt_q == '0) begin
          m_q[comp_q] <= $signed(dv_signed[47:0]);
          comp_q      <= comp_q + 2'd1;
        end
        if ((state_q == S_SQRT && sq_cnt_q == '0) ||
            (state_q == S_SDIV && dv_cnt_q == '0 && comp_q != kts_pkg::LAST_COMP)) begin
          dv_quo_q <= sl_mag;
          dv_rem_q <= '0;
          dv_den_q <= {15'b0, sq_root_q[30:14]};
          dv_neg_q <= sl_sum[48];
          dv_cnt_q <= 7'd64;
        end
      end
      S_SUPD: begin
        for (int i = 0; i < 4; i++) begin
          if (f_lo[k_q]) begin
            a_q[i] <= m_q[i];
          end else begin
            b_q[i] <= m_q[i];
          end
        end
        k_q       <= k_q - 4'd1;
        comp_q    <= '0;
        sq_rad_q  <= {1'b0, c_sum[31:1], 30'b0};
        sq_rem_q  <= '0;
        sq_root_q <= '0;
        sq_cnt_q  <= 5'd31;
      end
      S_SOUT: begin
        for (int i = 0; i < 4; i++) begin
          out_q[i] <= kts_pkg::sat32(64'(a_q[i] >>> 8));
        end
      end
      S_LACC: begin
        out_q[comp_q] <= kts_pkg::sat32(64'(prod_q >>> 16) + 64'(pa_q[comp_q]));
        comp_q        <= comp_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign done_o              = (state_q == S_DONE);
  assign result_o.out_x      = out_q[0];
  assign result_o.out_y      = out_q[1];
  assign result_o.out_z      = out_q[2];
  assign result_o.out_w      = out_q[3];
  assign result_o.local_time = ltime_q;
  assign result_o.status     = status_q;

`ifndef SYNTHESIS
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe outside a transaction");

  a_start_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted transaction not started");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == kts_pkg::ST_EMPTY |->
      result_o.out_x == '0 && result_o.out_y == '0 &&
      result_o.out_z == '0 && result_o.out_w == '0)
    else $error("empty track returned a value");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for the keyframe track sampler: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import kts_pkg::*;

  localparam int NTRK = 64;
  localparam int NKEY = 32;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  item_t       item_i;
  logic        busy_o;
  logic        done_o;
  res_t        result_o;
  logic        cfg_we_i;
  logic [30:0] cfg_wdata_i;

  keyframe_track_sampler_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow of the block's stores and clip length.
  logic [31:0]        key_tm [NTRK][NKEY];
  logic signed [31:0] key_val[NTRK][NKEY][4];
  bit                 key_set[NTRK][NKEY];
  int                 trk_len[NTRK];
  bit                 trk_sph[NTRK];
  logic [31:0]        clip_dur;

  res_t exp_q[$];
  int   n_err;
  bit   calm;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint asr16(longint v);
    return v >>> 16;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Shortest-path bisection slerp; falls back to lerp for nearly parallel keys.
  task automatic slerp_keys(input longint p[4], input longint qi[4], input longint f,
                            output longint rs[4]);
    longint q[4], a[4], b[4], m[4], dot, d;
    longint unsigned c, h;
    dot = 0;
    for (int i = 0; i < 4; i++) dot += asr16(p[i] * qi[i]);
    for (int i = 0; i < 4; i++) q[i] = (dot < 0) ? -qi[i] : qi[i];
    if (dot < 0) dot = -dot;
    if (dot > 65535) begin
      for (int i = 0; i < 4; i++) rs[i] = p[i] + asr16((q[i] - p[i]) * f);
      return;
    end
    if (f >= 65536) begin
      for (int i = 0; i < 4; i++) rs[i] = q[i];
      return;
    end
    c = longint'(dot) << 14;
    for (int i = 0; i < 4; i++) begin
      a[i] = p[i] * 256;
      b[i] = q[i] * 256;
    end
    for (int k = 15; k >= 0; k--) begin
      h = int_sqrt(((64'd1 << 30) + c) >> 1 << 30);
      d = longint'(h >> 14);
      if (d <= 0) d = 1;
      for (int i = 0; i < 4; i++) m[i] = ((a[i] + b[i]) * 32768) / d;
      if ((f >> k) & 1) a = m;
      else b = m;
      c = h;
    end
    for (int i = 0; i < 4; i++) rs[i] = a[i] >>> 8;
  endtask

  // Update the shadow state and work out the transaction's result.
  task automatic predict_result(input item_t it, output res_t r);
    logic [31:0] t, st, en;
    int ln, s, nx, tr;
    longint f, q, pa[4], pb[4], rs[4];
    r = '0;
    tr = it.track;
    case (it.cmd)
      CMD_WRITE: begin
        key_tm[tr][it.key_index] = {1'b0, it.key_time};
        key_val[tr][it.key_index][0] = it.comp_x;
        key_val[tr][it.key_index][1] = it.comp_y;
        key_val[tr][it.key_index][2] = it.comp_z;
        key_val[tr][it.key_index][3] = it.comp_w;
        key_set[tr][it.key_index] = 1'b1;
      end
      CMD_SET: begin
        trk_len[tr] = (it.key_count > NKEY) ? NKEY : it.key_count;
        trk_sph[tr] = it.spherical;
      end
      CMD_SAMPLE: begin
        t = {1'b0, it.sample_time};
        if (it.looping) t = (clip_dur == 0) ? 32'd0 : t % clip_dur;
        else if (t > clip_dur) t = clip_dur;
        r.local_time = t[30:0];
        ln = trk_len[tr];
        if (ln == 0) begin
          r.status = ST_EMPTY;
          return;
        end
        s = 0;
        while (s < ln && t >= key_tm[tr][s]) s++;
        if (ln == 1 || s == 0) begin
          r.out_x = key_val[tr][0][0];
          r.out_y = key_val[tr][0][1];
          r.out_z = key_val[tr][0][2];
          r.out_w = key_val[tr][0][3];
          r.status = (ln == 1) ? ST_SINGLE : ST_OK;
          return;
        end
        st = key_tm[tr][s-1];
        en = (s >= ln) ? clip_dur : key_tm[tr][s];
        nx = (s >= ln) ? 0 : s;
        f = 0;
        if (en > st) begin
          q = (longint'(t - st) << 16) / longint'(en - st);
          f = (q > 65536) ? 65536 : q;
        end
        for (int i = 0; i < 4; i++) begin
          pa[i] = key_val[tr][s-1][i];
          pb[i] = key_val[tr][nx][i];
        end
        if (trk_sph[tr]) slerp_keys(pa, pb, f, rs);
        else for (int i = 0; i < 4; i++) rs[i] = pa[i] + asr16((pb[i] - pa[i]) * f);
        r.out_x = clip32(rs[0]);
        r.out_y = clip32(rs[1]);
        r.out_z = clip32(rs[2]);
        r.out_w = clip32(rs[3]);
      end
      default: ;
    endcase
  endtask

  // Number of keys written from slot 0 without a hole: the most a set may enable.
  function automatic int ready_keys(int tr);
    int n;
    n = 0;
    while (n < NKEY && key_set[tr][n]) n++;
    return n;
  endfunction

  function automatic item_t wr_item(int tr, int k, logic [30:0] t, logic [31:0] x,
                                    logic [31:0] y, logic [31:0] z, logic [31:0] w);
    item_t it;
    it = '0;
    it.cmd = CMD_WRITE;
    it.track = tr;
    it.key_index = k;
    it.key_time = t;
    it.comp_x = x;
    it.comp_y = y;
    it.comp_z = z;
    it.comp_w = w;
    return it;
  endfunction

  function automatic item_t set_item(int tr, int n, bit sph);
    item_t it;
    it = '0;
    it.cmd = CMD_SET;
    it.track = tr;
    it.key_count = n;
    it.spherical = sph;
    return it;
  endfunction

  function automatic item_t smp_item(int tr, logic [30:0] t, bit lp);
    item_t it;
    it = '0;
    it.cmd = CMD_SAMPLE;
    it.track = tr;
    it.sample_time = t;
    it.looping = lp;
    return it;
  endfunction

  function automatic res_t mk_res(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic [31:0] w, logic [30:0] lt, logic [1:0] stat);
    res_t r;
    r.out_x = x;
    r.out_y = y;
    r.out_z = z;
    r.out_w = w;
    r.local_time = lt;
    r.status = stat;
    return r;
  endfunction

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 99) < 38) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Hold start until the block takes the transaction, then queue its result.
  task automatic send(input item_t it, input bit typed = 1'b0, input res_t want = '0);
    res_t r;
    idle_gap();
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    predict_result(it, r);
    exp_q.push_back(typed ? want : r);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_clip(logic [30:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    clip_dur = {1'b0, v};
  endtask

  function automatic logic [31:0] rand_comp(bit sph);
    if (sph) return $urandom_range(0, 131072) - 65536;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_time(longint span);
    longint v;
    v = longint'({$urandom, $urandom}) % (span + 1);
    if (v > 64'h7FFFFFFF) v = 64'h7FFFFFFF;
    return v[30:0];
  endfunction

  // One well-formed track: keys in non-decreasing time order, set, then a few samples.
  task automatic track_burst(output int n_sent);
    int tr, n, cnt;
    bit sph;
    longint span, tk;
    logic [30:0] tt;
    tr = $urandom_range(0, NTRK - 1);
    n = ($urandom_range(0, 9) == 0) ? NKEY : $urandom_range(1, 6);
    sph = ($urandom_range(0, 9) < 3);
    span = (clip_dur == 0) ? 64'h10000 : longint'(clip_dur);
    if ($urandom_range(0, 5) == 0) span = 64'h7FFFFFFF;
    tk = $urandom_range(0, 3) == 0 ? 0 : longint'(rand_time(span / 4));
    n_sent = 0;
    for (int k = 0; k < n; k++) begin
      if (tk > 64'h7FFFFFFF) tk = 64'h7FFFFFFF;
      send(wr_item(tr, k, tk[30:0], rand_comp(sph), rand_comp(sph), rand_comp(sph),
                   rand_comp(sph)));
      n_sent++;
      // Repeat a time stamp now and then to get zero-length intervals.
      if ($urandom_range(0, 7) != 0) tk += longint'(rand_time(span / n + 1)) + 1;
    end
    cnt = n;
    if (n == NKEY && $urandom_range(0, 1)) cnt = $urandom_range(NKEY, 63);
    else if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, ready_keys(tr));
    send(set_item(tr, cnt, sph));
    n_sent++;
    repeat ($urandom_range(1, 4)) begin
      tt = ($urandom_range(0, 4) == 0) ? rand_time(64'h7FFFFFFF) : rand_time(span + span / 4);
      send(smp_item(tr, tt, $urandom_range(0, 1)));
      n_sent++;
    end
  endtask

  task automatic noise_item();
    logic [223:0] raw;
    item_t it;
    int lim;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    if (it.cmd == CMD_SET) begin
      lim = ready_keys(it.track);
      if (lim < NKEY && it.key_count > lim) it.key_count = $urandom_range(0, lim);
    end
    send(it);
  endtask

  task automatic run_directed();
    row_t tbl[$];
    tbl.push_back('{smp_item(0, 31'h7FFFFFFF, 0), 1, mk_res(0, 0, 0, 0, 31'd65536, ST_EMPTY)});
    tbl.push_back('{smp_item(5, 31'd70000, 1), 1, mk_res(0, 0, 0, 0, 31'd4464, ST_EMPTY)});
    tbl.push_back('{item_t'({2'd3, 209'd0}), 1, mk_res(0, 0, 0, 0, 0, ST_OK)});
    tbl.push_back('{wr_item(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF), 1,
                    mk_res(0, 0, 0, 0, 0, ST_OK)});
    tbl.push_back('{set_item(0, 1, 0), 1, mk_res(0, 0, 0, 0, 0, ST_OK)});
    tbl.push_back('{smp_item(0, 31'd100, 0), 1,
                    mk_res(32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF, 31'd100, ST_SINGLE)});
    tbl.push_back('{wr_item(0, 1, 31'h8000, 32'h80000000, 32'h7FFFFFFF, 5, 32'hFFFFFFFF), 0,
                    '0});
    tbl.push_back('{set_item(0, 2, 0), 0, '0});
    tbl.push_back('{smp_item(0, 31'h4000, 1), 0, '0});
    tbl.push_back('{smp_item(0, 31'h8000, 0), 0, '0});
    tbl.push_back('{smp_item(0, 31'hC000, 1), 0, '0});
    tbl.push_back('{smp_item(0, 31'h7FFFFFFF, 1), 0, '0});
    tbl.push_back('{wr_item(63, 0, 31'h8000, 32'h10000, 0, 0, 0), 0, '0});
    tbl.push_back('{wr_item(63, 1, 31'hC000, 0, 32'h10000, 0, 0), 0, '0});
    tbl.push_back('{wr_item(63, 2, 31'hE000, 0, 32'hFFFF4AFB, 0, 32'hFFFF4AFB), 0, '0});
    tbl.push_back('{set_item(63, 3, 1), 0, '0});
    // Before the first key the first key is held with a plain status.
    tbl.push_back('{smp_item(63, 31'h0, 0), 1, mk_res(32'h10000, 0, 0, 0, 0, ST_OK)});
    tbl.push_back('{smp_item(63, 31'hA000, 0), 0, '0});
    tbl.push_back('{smp_item(63, 31'hD000, 0), 0, '0});
    tbl.push_back('{smp_item(63, 31'hF000, 1), 0, '0});
    tbl.push_back('{smp_item(63, 31'h10000, 0), 0, '0});
    tbl.push_back('{set_item(0, 0, 1), 0, '0});
    tbl.push_back('{smp_item(0, 31'h10, 1), 1, mk_res(0, 0, 0, 0, 31'h10, ST_EMPTY)});
    foreach (tbl[i]) send(tbl[i].it, tbl[i].typed, tbl[i].want);
  endtask

  task automatic run_random(int budget);
    int sent, k;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 2) begin
        noise_item();
        sent++;
      end else begin
        track_burst(k);
        sent += k;
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t w;
    if (rst_ni && done_o) begin
      if (exp_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result %h", $time, result_o);
      end else begin
        w = exp_q.pop_front();
        if (w.out_x !== result_o.out_x)
          $display("%0t: out_x expected %h actual %h", $time, w.out_x, result_o.out_x);
        if (w.out_y !== result_o.out_y)
          $display("%0t: out_y expected %h actual %h", $time, w.out_y, result_o.out_y);
        if (w.out_z !== result_o.out_z)
          $display("%0t: out_z expected %h actual %h", $time, w.out_z, result_o.out_z);
        if (w.out_w !== result_o.out_w)
          $display("%0t: out_w expected %h actual %h", $time, w.out_w, result_o.out_w);
        if (w.local_time !== result_o.local_time)
          $display("%0t: local_time expected %h actual %h", $time, w.local_time,
                   result_o.local_time);
        if (w.status !== result_o.status)
          $display("%0t: status expected %h actual %h", $time, w.status, result_o.status);
        if (w !== result_o) n_err++;
      end
    end
  end

  initial begin
    #(64'd300_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    n_err = 0;
    calm = 1'b0;
    clip_dur = {1'b0, DUR_RESET};
    foreach (trk_len[i]) begin
      trk_len[i] = 0;
      trk_sph[i] = 1'b0;
      for (int k = 0; k < NKEY; k++) key_set[i][k] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(330);
    set_clip(31'h7FFFFFFF);
    run_random(300);
    // Stretch with no gaps at all.
    calm = 1'b1;
    set_clip(31'd0);
    run_random(300);
    calm = 1'b0;
    set_clip(31'd3);
    run_random(150);
    set_clip(31'h00030000);
    run_random(280);
    set_clip(31'($urandom_range(1, 32'h00200000)));
    run_random(260);

    drain();
    repeat (100) @(posedge clk_i);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> keyframe_track_sampler_top.f
hdl/kts_pkg.sv
hdl/kts_ram.sv
hdl/keyframe_track_sampler_top.sv
test/testbench.sv
